// ===== rtl/rpd_pkg.sv =====
// Shared types and constants of the ring-LWE decryption core.
// No dependencies; imported by every module of the core.
package rpd_pkg;

	localparam int COEF_BITS  = 50;
	localparam int MAX_DEGREE = 1024;
	localparam int ADDR_W     = $clog2(MAX_DEGREE);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int INDEX_W    = 10;
	localparam int DEG_W      = 11;
	localparam int KEY_W      = 2;
	// |acc| < MAX_DEGREE * 2 * 2^COEF_BITS + 2^COEF_BITS, plus sign
	localparam int ACC_W      = COEF_BITS + ADDR_W + 3;
	localparam int RED_CNT_W  = $clog2(ACC_W);

	// request packing
	localparam int IN_IDX_LSB = 0;
	localparam int IN_C0_LSB  = IN_IDX_LSB + INDEX_W;
	localparam int IN_C1_LSB  = IN_C0_LSB + COEF_BITS;
	localparam int IN_KEY_LSB = IN_C1_LSB + COEF_BITS;
	localparam int S_TDATA_W  = ((IN_KEY_LSB + KEY_W + 7) / 8) * 8;

	localparam int OUT_IDX_LSB = 0;
	localparam int OUT_VAL_LSB = OUT_IDX_LSB + INDEX_W;
	localparam int M_TDATA_W   = ((OUT_VAL_LSB + COEF_BITS + 7) / 8) * 8;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COEF_BITS;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE  = 1'b1;
	localparam logic [COEF_BITS-1:0] MODULUS_RST = {COEF_BITS{1'b1}};
	localparam logic [DEG_W-1:0]     DEGREE_RST  = DEG_W'(MAX_DEGREE);

	// request kinds
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// ternary key codes (10b counts as -2)
	localparam logic [KEY_W-1:0] KEY_ZERO = 2'b00;
	localparam logic [KEY_W-1:0] KEY_POS1 = 2'b01;
	localparam logic [KEY_W-1:0] KEY_NEG2 = 2'b10;
	localparam logic [KEY_W-1:0] KEY_NEG1 = 2'b11;

	typedef struct packed {
		logic load;
		logic start;
		logic step;
		logic red_start;
		logic emit;
	} rpd_cmd_t;

	typedef struct packed {
		logic idx_ok;
		logic walk_last;
		logic red_done;
		logic out_free;
	} rpd_stat_t;

endpackage

// ===== rtl/rpd_reduce.sv =====
// Bit-serial reduction of the signed accumulator modulo q, one bit per cycle.
// Depends on rpd_pkg.
module rpd_reduce import rpd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] acc,
	input  logic [COEF_BITS-1:0]    modulus,
	output logic                    done,
	output logic [COEF_BITS-1:0]    value
);

	logic                 busy_q;
	logic                 done_q;
	logic [RED_CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]     mag_q;
	logic [COEF_BITS-1:0] r_q;
	logic                 neg_q;
	logic [COEF_BITS:0]   trial;
	logic [COEF_BITS:0]   diff;
	logic                 ge;

	assign trial = {r_q, mag_q[ACC_W-1]};
	assign diff  = trial - {1'b0, modulus};
	assign ge    = trial >= {1'b0, modulus};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == RED_CNT_W'(ACC_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= acc[ACC_W-1];
			mag_q <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
			r_q   <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			r_q   <= ge ? diff[COEF_BITS-1:0] : trial[COEF_BITS-1:0];
			mag_q <= {mag_q[ACC_W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		if (modulus == '0)
			value = '0;
		else if (neg_q && r_q != '0)
			value = modulus - r_q;
		else
			value = r_q;
	end

	assign done = done_q;

endmodule

// ===== rtl/rpd_datapath.sv =====
// Datapath: coefficient stores, key-index walk, MAC accumulator, reducer, output register.
// Depends on rpd_pkg and rpd_reduce.
module rpd_datapath import rpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rpd_cmd_t              cmd,
	output rpd_stat_t             stat,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic [COEF_BITS-1:0]  modulus,
	input  logic [DEG_W-1:0]      degree,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [M_TDATA_W-1:0]  m_tdata
);

	logic [COEF_BITS-1:0] c0_mem  [MAX_DEGREE];
	logic [COEF_BITS-1:0] c1_mem  [MAX_DEGREE];
	logic [KEY_W-1:0]     key_mem [MAX_DEGREE];

	logic [INDEX_W-1:0]   in_index;
	logic [COEF_BITS-1:0] in_c0;
	logic [COEF_BITS-1:0] in_c1;
	logic [KEY_W-1:0]     in_key;
	logic [ADDR_W-1:0]    in_addr;

	logic [CNT_W-1:0]     n_eff;
	logic [ADDR_W-1:0]    k_q;
	logic [ADDR_W-1:0]    kidx_q;
	logic [CNT_W-1:0]     j_q;
	logic [COEF_BITS-1:0] c0_rd_q;
	logic [COEF_BITS-1:0] c1_s1;
	logic [KEY_W-1:0]     key_s1;
	logic                 wrap_s1;
	logic                 vld_s1;
	logic                 start_d_q;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term_mag;
	logic signed [ACC_W-1:0] term;
	logic                    term_neg;

	logic                 red_done;
	logic [COEF_BITS-1:0] red_value;

	logic                 out_valid_q;
	logic [INDEX_W-1:0]   out_index_q;
	logic [COEF_BITS-1:0] out_value_q;

	assign in_index = s_tdata[IN_IDX_LSB +: INDEX_W];
	assign in_c0    = s_tdata[IN_C0_LSB +: COEF_BITS];
	assign in_c1    = s_tdata[IN_C1_LSB +: COEF_BITS];
	assign in_key   = s_tdata[IN_KEY_LSB +: KEY_W];
	assign in_addr  = in_index[ADDR_W-1:0];

	// effective ring degree, clamped to [1, MAX_DEGREE]
	always_comb begin
		if (degree == '0)
			n_eff = CNT_W'(1);
		else if (degree > DEG_W'(MAX_DEGREE))
			n_eff = CNT_W'(MAX_DEGREE);
		else
			n_eff = CNT_W'(degree);
	end

	// stores
	always_ff @(posedge clk) begin
		if (cmd.load && DEG_W'(in_index) < DEG_W'(MAX_DEGREE))
			c0_mem[in_addr] <= in_c0;
		if (cmd.start)
			c0_rd_q <= c0_mem[in_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load && DEG_W'(in_index) < DEG_W'(MAX_DEGREE))
			c1_mem[in_addr] <= in_c1;
		if (cmd.step)
			c1_s1 <= c1_mem[j_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load && DEG_W'(in_index) < DEG_W'(MAX_DEGREE))
			key_mem[in_addr] <= in_key;
		if (cmd.step)
			key_s1 <= key_mem[kidx_q];
	end

	// walk: j runs up, key index runs down and wraps to n-1
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			k_q    <= in_addr;
			kidx_q <= in_addr;
			j_q    <= '0;
		end else if (cmd.step) begin
			j_q     <= j_q + 1'b1;
			kidx_q  <= (kidx_q == '0) ? ADDR_W'(n_eff - 1'b1) : kidx_q - 1'b1;
			wrap_s1 <= j_q > CNT_W'(k_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			start_d_q <= 1'b0;
		end else begin
			vld_s1    <= cmd.step;
			start_d_q <= cmd.start;
		end
	end

	// term = c1 * s, negated past the wrap (X^N = -1)
	always_comb begin
		term_mag = (key_s1 == KEY_NEG2) ? ACC_W'({c1_s1, 1'b0}) : ACC_W'(c1_s1);
		term_neg = (key_s1 inside {KEY_NEG1, KEY_NEG2}) ^ wrap_s1;
		if (key_s1 == KEY_ZERO)
			term = '0;
		else if (term_neg)
			term = -term_mag;
		else
			term = term_mag;
	end

	always_ff @(posedge clk) begin
		if (start_d_q)
			acc_q <= ACC_W'(c0_rd_q);
		else if (vld_s1)
			acc_q <= acc_q + term;
	end

	rpd_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.red_start),
		.acc     (acc_q),
		.modulus (modulus),
		.done    (red_done),
		.value   (red_value)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_index_q <= INDEX_W'(k_q);
			out_value_q <= red_value;
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[OUT_IDX_LSB +: INDEX_W]   = out_index_q;
		m_tdata[OUT_VAL_LSB +: COEF_BITS] = out_value_q;
	end

	assign m_tvalid       = out_valid_q;
	assign stat.idx_ok    = DEG_W'(in_index) < n_eff;
	assign stat.walk_last = j_q == n_eff - 1'b1;
	assign stat.red_done  = red_done;
	assign stat.out_free  = !out_valid_q || m_tready;

endmodule

// ===== rtl/rpd_ctrl.sv =====
// Controller state machine: accepts requests, sequences walk, reduction and output.
// Depends on rpd_pkg.
module rpd_ctrl import rpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      s_tuser,
	output logic      s_tready,
	input  rpd_stat_t stat,
	output rpd_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_WALK   = 6'b000010,
		ST_DRAIN  = 6'b000100,
		ST_RSTART = 6'b001000,
		ST_REDUCE = 6'b010000,
		ST_OUT    = 6'b100000
	} rpd_state_t;

	rpd_state_t state_q;
	rpd_state_t state_nxt;
	logic       accept;

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load  = accept && s_tuser == OP_LOAD;
				cmd.start = accept && s_tuser == OP_READ && stat.idx_ok;
				if (cmd.start)
					state_nxt = ST_WALK;
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (stat.walk_last)
					state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_RSTART;
			end
			ST_RSTART: begin
				cmd.red_start = 1'b1;
				state_nxt     = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (stat.red_done)
					state_nxt = ST_OUT;
			end
			ST_OUT: begin
				cmd.emit = stat.out_free;
				if (stat.out_free)
					state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule

// ===== rtl/rlwe_polynomial_decryption_core.sv =====
// Top level of the negacyclic ring-LWE decryption core.
// Depends on rpd_pkg, rpd_ctrl and rpd_datapath.

// Decrypts m = c0 + c1*s in Z_q[X]/(X^N+1), one coefficient per read request.
// A load request (tuser = 0) writes c0, c1 and the ternary key coefficient at
// one index into three 1024-deep stores. A read request (tuser = 1) for index
// k returns (c0[k] + sum_j c1[j]*s[k-j]) mod q, with the wrapped terms negated;
// reads with k >= N give no result. Entries must be loaded before they are
// read. A read occupies the core from its accept to the next accept: a walk of
// the c1 and key stores one entry per cycle (one read port each), bit-serial
// reduction of the exact 63-bit sum modulo q, and sequencing (pipeline drain,
// reducer start, reducer done, output, accept). If the previous result still
// waits in the output register, the read holds in its output step until
// m_tready frees it. The result sits in an output register, so the next
// request is accepted while it waits for m_tready. modulus and degree are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while idle, a rule which the core itself leaves unenforced.
module rlwe_polynomial_decryption_core import rpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,   // 0 modulus, 1 degree
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,     // index[9:0], c0_coef, c1_coef, key_coef
	input  logic                  s_tuser,     // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata      // result_index[9:0], result_value, zero pad
);

	logic [COEF_BITS-1:0] modulus_q;
	logic [DEG_W-1:0]     degree_q;
	rpd_cmd_t             dp_cmd;
	rpd_stat_t            dp_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
			degree_q  <= DEGREE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS: modulus_q <= cfg_data[COEF_BITS-1:0];
				REG_DEGREE:  degree_q  <= cfg_data[DEG_W-1:0];
				default:     ;
			endcase
		end
	end

	rpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	rpd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dp_cmd),
		.stat     (dp_stat),
		.s_tdata  (s_tdata),
		.modulus  (modulus_q),
		.degree   (degree_q),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

`ifndef ASSERT_OFF
	// a walk starts only on an accepted read request
	a_start_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.start |-> (s_tvalid && s_tready && s_tuser == OP_READ))
		else $error("walk started without an accepted read request");

	// once a read is under way no further request is taken
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.start |=> !s_tready)
		else $error("request accepted while a read is in progress");

	// every result is reduced below a nonzero modulus
	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.emit && modulus_q != '0) |=>
			(m_tdata[OUT_VAL_LSB +: COEF_BITS] < modulus_q))
		else $error("result value not below modulus");
`endif

endmodule
